// ===== hw/rtl/polyphonic_adsr_voice_manager_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the voice manager
// Shared concurrent assertion forms clocked on clk with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_ADSR_VOICE_MANAGER_TOP_ASSERT_SVH
`define POLYPHONIC_ADSR_VOICE_MANAGER_TOP_ASSERT_SVH

// Same-cycle implication.
`define PAVM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PAVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pavm_pkg.sv =====
// ----------------------------------------------------------------------------
// pavm_pkg
// Types and constants shared by the voice manager modules.
// ----------------------------------------------------------------------------
package pavm_pkg;

  localparam int IDXW = 6;  // widest voice index (up to 64 voices)

  localparam logic [1:0] REQ_ON   = 2'd0;
  localparam logic [1:0] REQ_OFF  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ATTACK  = 3'd1;
  localparam logic [2:0] PH_DECAY   = 3'd2;
  localparam logic [2:0] PH_SUSTAIN = 3'd3;
  localparam logic [2:0] PH_RELEASE = 3'd4;

  localparam logic [1:0] CFG_ATTACK  = 2'd0;
  localparam logic [1:0] CFG_DECAY   = 2'd1;
  localparam logic [1:0] CFG_SUSTAIN = 2'd2;
  localparam logic [1:0] CFG_RELEASE = 2'd3;

  localparam logic [31:0] LEVEL_MAX     = 32'hFFFF_FFFF;
  localparam logic [31:0] RST_LENGTH    = 32'd44100;
  localparam logic [31:0] RST_SUSTAIN   = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [6:0]  note;
    logic [2:0]  phase;
    logic [31:0] level;
    logic [31:0] rate;
    logic [31:0] age;
  } voice_t;

  // controller to datapath
  typedef struct packed {
    logic            load;       // latch the accepted item, clear scan state
    logic            rd;         // read voice at idx
    logic            rd_pick;    // read the picked voice
    logic            scan;       // evaluate the voice just read
    logic            div_start;  // start the rate division
    logic            wr;         // update the voice and emit a result
    logic [IDXW-1:0] idx;
    logic            last;       // idx is the final voice
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req;
    logic       cur_idle;
    logic       have_pick;
    logic       need_div;
    logic       div_done;
    logic       out_free;
  } stat_t;

endpackage

// ===== hw/rtl/pavm_div.sv =====
// ----------------------------------------------------------------------------
// pavm_div
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pavm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic        done,
  output logic [31:0] quo
);

  logic [31:0] rem_r;
  logic [31:0] q_r;
  logic [31:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] trial;

  assign trial = {rem_r, q_r[31]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 32'd0;
      q_r   <= num;
      den_r <= (den == 32'd0) ? 32'd1 : den;  // treat a zero length as one
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_r <= trial[31:0];
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[30:0], q_r[31]};
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== hw/rtl/pavm_datapath.sv =====
// ----------------------------------------------------------------------------
// pavm_datapath
// Voice memory, scan registers, envelope step, divider and result register.
// ----------------------------------------------------------------------------
`include "polyphonic_adsr_voice_manager_top_assert.svh"

module pavm_datapath
  import pavm_pkg::*;
#(
  parameter int VOICE_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [7:0]  in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic        out_tlast
);

  localparam int AW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  voice_t                 mem [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] vld_r;
  voice_t                 mem_q;
  logic                   rd_vld_r;
  voice_t                 rd;

  logic [31:0] att_len_r, dec_len_r, sus_r, rel_len_r;
  logic [31:0] start_cnt_r;
  logic [1:0]  req_r;
  logic [6:0]  note_r;

  logic          have_idle_r, have_r;
  logic [AW-1:0] idle_idx_r, pick_idx_r, oldest_idx_r;
  logic [31:0]   oldest_age_r, pick_age_r;
  logic [AW-1:0] pick;
  logic [AW-1:0] idx;

  logic [31:0] div_num, div_den, quo;
  logic        div_busy, div_done;

  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;
  logic        out_tlast_r;
  logic        out_free;

  voice_t      step_v;
  logic        att_end;
  logic [31:0] att_dist;
  voice_t      wr_v;
  logic [AW-1:0] wr_addr;
  logic [2:0]  res_phase;
  logic [31:0] res_amp;
  logic [AW-1:0] res_idx;
  logic        res_found, res_stolen;

  assign idx  = cmd.idx[AW-1:0];
  assign pick = (req_r == REQ_ON) ? (have_idle_r ? idle_idx_r : oldest_idx_r) : pick_idx_r;
  assign rd   = rd_vld_r ? mem_q : '0;  // never-written voices read as reset

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_len_r <= RST_LENGTH;
      dec_len_r <= RST_LENGTH;
      sus_r     <= RST_SUSTAIN;
      rel_len_r <= RST_LENGTH;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ATTACK:  att_len_r <= cfg_data;
        CFG_DECAY:   dec_len_r <= cfg_data;
        CFG_SUSTAIN: sus_r     <= cfg_data;
        CFG_RELEASE: rel_len_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  // voice memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr && !(req_r == REQ_OFF && !have_r)) begin
      mem[wr_addr] <= wr_v;
    end
    if (cmd.rd || cmd.rd_pick) begin
      mem_q <= mem[cmd.rd ? idx : pick];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.rd || cmd.rd_pick) begin
        rd_vld_r <= vld_r[cmd.rd ? idx : pick];
      end
      if (cmd.wr && !(req_r == REQ_OFF && !have_r)) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // item and scan registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_cnt_r <= 32'd0;
    end else if (cmd.wr && req_r == REQ_ON) begin
      start_cnt_r <= start_cnt_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r       <= in_tuser;
      note_r      <= in_tdata[6:0];
      have_idle_r <= 1'b0;
      have_r      <= 1'b0;
    end else if (cmd.scan) begin
      if (req_r == REQ_ON) begin
        if (rd.phase == PH_IDLE) begin
          have_idle_r <= 1'b1;
          idle_idx_r  <= idx;
        end else if (idx == '0 || rd.age < oldest_age_r) begin
          oldest_idx_r <= idx;
          oldest_age_r <= rd.age;
        end
      end else if (req_r == REQ_OFF) begin
        if (rd.note == note_r && rd.phase != PH_IDLE && rd.phase != PH_RELEASE &&
            (!have_r || rd.age < pick_age_r)) begin
          have_r     <= 1'b1;
          pick_idx_r <= idx;
          pick_age_r <= rd.age;
        end
      end
    end
  end

  // envelope step for a tick
  assign att_dist = LEVEL_MAX - rd.level;
  assign att_end  = (att_dist <= rd.rate);

  always_comb begin
    step_v = rd;
    case (rd.phase)
      PH_ATTACK: begin
        if (att_end) begin
          step_v.level = LEVEL_MAX;
          step_v.phase = PH_DECAY;
          step_v.rate  = quo;
        end else begin
          step_v.level = rd.level + rd.rate;
        end
      end
      PH_DECAY: begin
        if (rd.level <= sus_r || (rd.level - sus_r) <= rd.rate) begin
          step_v.level = sus_r;
          step_v.phase = PH_SUSTAIN;
        end else begin
          step_v.level = rd.level - rd.rate;
        end
      end
      PH_RELEASE: begin
        if (rd.level <= rd.rate) begin
          step_v.level = 32'd0;
          step_v.phase = PH_IDLE;
        end else begin
          step_v.level = rd.level - rd.rate;
        end
      end
      default: ;
    endcase
  end

  // divider operands follow the request
  always_comb begin
    case (req_r)
      REQ_ON: begin
        div_num = LEVEL_MAX - rd.level;
        div_den = att_len_r;
      end
      REQ_OFF: begin
        div_num = rd.level;
        div_den = rel_len_r;
      end
      default: begin
        div_num = LEVEL_MAX - sus_r;
        div_den = dec_len_r;
      end
    endcase
  end

  pavm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  // write data and result fields
  always_comb begin
    wr_v       = rd;
    wr_addr    = pick;
    res_idx    = pick;
    res_found  = 1'b1;
    res_stolen = 1'b0;
    res_phase  = PH_IDLE;
    res_amp    = rd.level;
    case (req_r)
      REQ_ON: begin
        wr_v.note  = note_r;
        wr_v.phase = PH_ATTACK;
        wr_v.rate  = quo;
        wr_v.age   = start_cnt_r;
        res_stolen = !have_idle_r;
        res_phase  = PH_ATTACK;
      end
      REQ_OFF: begin
        wr_v.phase = PH_RELEASE;
        wr_v.rate  = quo;
        if (have_r) begin
          res_phase = PH_RELEASE;
        end else begin
          res_idx   = '0;
          res_found = 1'b0;
          res_amp   = 32'd0;
        end
      end
      default: begin
        wr_v      = step_v;
        wr_addr   = idx;
        res_idx   = idx;
        res_phase = step_v.phase;
        res_amp   = step_v.level;
      end
    endcase
  end

  // result register
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.wr) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      out_tdata_r <= {5'd0, res_amp, res_phase, res_stolen, res_found, IDXW'(res_idx)};
      out_tlast_r <= (req_r != REQ_TICK) || cmd.last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  assign stat.req       = req_r;
  assign stat.cur_idle  = (rd.phase == PH_IDLE);
  assign stat.have_pick = have_r;
  assign stat.need_div  = (rd.phase == PH_ATTACK) && att_end;
  assign stat.div_done  = div_done;
  assign stat.out_free  = out_free;

  `PAVM_ASSERT_IMPL(a_emit_free, cmd.wr, out_free, "result overwritten before taken")
  `PAVM_ASSERT_IMPL(a_div_idle, cmd.div_start, !div_busy, "divider restarted while busy")
  `PAVM_ASSERT_NEXT(a_age_step, cmd.wr && req_r == REQ_ON,
                    start_cnt_r == $past(start_cnt_r) + 32'd1, "age stamp not advanced")

endmodule

// ===== hw/rtl/pavm_ctrl.sv =====
// ----------------------------------------------------------------------------
// pavm_ctrl
// Sequencer for scan, pick, divide and write-back of one item.
// ----------------------------------------------------------------------------
module pavm_ctrl
  import pavm_pkg::*;
#(
  parameter int VOICE_COUNT = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] in_tuser,
  input  stat_t      stat,
  output cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_PRD  = 3'd3;
  localparam logic [2:0] S_PDIV = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_WR   = 3'd6;

  localparam logic [IDXW-1:0] LAST = IDXW'(VOICE_COUNT - 1);

  logic [2:0]      state_r, state_nxt;
  logic [IDXW-1:0] idx_r, idx_nxt;
  logic            last;

  assign last = (idx_r == LAST);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    cmd.last  = last;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          idx_nxt  = '0;
          if (in_tuser != REQ_NONE) begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        if (stat.req == REQ_TICK) begin
          if (stat.need_div) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            state_nxt = S_WR;
          end
        end else begin
          cmd.scan = 1'b1;
          if (last || (stat.req == REQ_ON && stat.cur_idle)) begin
            state_nxt = S_PRD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_PRD: begin
        cmd.rd_pick = 1'b1;
        if (stat.req == REQ_OFF && !stat.have_pick) begin
          state_nxt = S_WR;  // no match: report not found
        end else begin
          state_nxt = S_PDIV;
        end
      end
      S_PDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        if (stat.out_free) begin
          cmd.wr = 1'b1;
          if (stat.req == REQ_TICK && !last) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== hw/rtl/polyphonic_adsr_voice_manager_top.sv =====
// ----------------------------------------------------------------------------
// polyphonic_adsr_voice_manager_top
// ADSR envelope voice bank with oldest-voice stealing on note-on.
// ----------------------------------------------------------------------------
// Sequence: a note-on or note-off scans the voices, reads the pick, runs the
//   rate divider and writes back (a note-off with no match skips the divider);
//   a tick steps each voice in turn and divides for each that ends its attack.
// Throughput: one item at a time; the voice scan reads the voice memory one
//   voice at a time, and the rate divider is serial.
// Reset: synchronous, active-low rst_n; all voices read idle at once, no sweep.
// ----------------------------------------------------------------------------
module polyphonic_adsr_voice_manager_top
  import pavm_pkg::*;
#(
  parameter int VOICE_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [6:0] note_number
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [5:0] voice_index, [6] found, [7] stolen,
                                  // [10:8] phase, [42:11] amplitude
  output logic        out_tlast,  // last_of_run
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // Registers are always writable.
  assign cfg_ready = 1'b1;

  pavm_ctrl #(.VOICE_COUNT(VOICE_COUNT)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  pavm_datapath #(.VOICE_COUNT(VOICE_COUNT)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/polyphonic_adsr_voice_manager_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_adsr_voice_manager_top_test
// Self-checking bench for the ADSR voice bank. Requests are streamed in with
// random gaps, results are drained with random and long back-pressure, and
// every result is compared against an in-bench envelope and allocation model.
// ----------------------------------------------------------------------------
module polyphonic_adsr_voice_manager_top_test;
  import pavm_pkg::*;

  localparam int VOICES      = 8;
  localparam int DRAIN_WAIT  = 400;      // covers a tick with every attack ending
  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD   = 600;

  typedef struct {
    logic [1:0] req;
    logic [6:0] note;
  } request_t;

  typedef struct {
    logic [5:0]  idx;
    logic        found;
    logic        stolen;
    logic [2:0]  phase;
    logic [31:0] amp;
    logic        last;
  } voice_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = REQ_NONE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ATTACK;
  logic [31:0] cfg_data = '0;

  polyphonic_adsr_voice_manager_top #(.VOICE_COUNT(VOICES)) uut (.*);

  always #1 clk = ~clk;

  // Model of the voice bank and its registers.
  logic [31:0] m_attack, m_decay, m_sustain, m_release;
  logic [6:0]  m_note [VOICES];
  logic [2:0]  m_phase[VOICES];
  logic [31:0] m_level[VOICES];
  logic [31:0] m_rate [VOICES];
  logic [31:0] m_age  [VOICES];
  logic [31:0] m_stamp;

  request_t      note_requests[$];
  voice_report_t pending_reports[$];

  int  sender_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_go = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  bit  in_acc = 0;
  int  errors = 0;
  int  cycles = 0;
  int  n_requests = 0;
  int  n_reports = 0;
  int  n_steals = 0;

  function automatic logic [31:0] per_tick(logic [31:0] span, logic [31:0] len);
    return span / ((len == 0) ? 32'd1 : len);
  endfunction

  function automatic voice_report_t report(int idx, bit fnd, bit stl, logic [2:0] ph,
                                           logic [31:0] amp, bit last);
    voice_report_t r;
    r.idx = 6'(idx); r.found = fnd; r.stolen = stl; r.phase = ph; r.amp = amp; r.last = last;
    return r;
  endfunction

  // Advance one voice's envelope by one tick.
  task automatic advance_voice(int v);
    logic [31:0] lv, rt;
    lv = m_level[v];
    rt = m_rate[v];
    case (m_phase[v])
      PH_ATTACK: begin
        if (LEVEL_MAX - lv <= rt) begin
          m_level[v] = LEVEL_MAX;
          m_phase[v] = PH_DECAY;
          m_rate[v]  = per_tick(LEVEL_MAX - m_sustain, m_decay);
        end else m_level[v] = lv + rt;
      end
      PH_DECAY: begin
        if (lv <= m_sustain || lv - m_sustain <= rt) begin
          m_level[v] = m_sustain;
          m_phase[v] = PH_SUSTAIN;
        end else m_level[v] = lv - rt;
      end
      PH_RELEASE: begin
        if (lv <= rt) begin
          m_level[v] = 32'd0;
          m_phase[v] = PH_IDLE;
        end else m_level[v] = lv - rt;
      end
      default: ;
    endcase
  endtask

  // Apply one accepted request to the model and queue the reports it causes.
  task automatic apply_request(request_t rq);
    int pick, oldest;
    bit busy;
    pick = -1;
    oldest = 0;
    case (rq.req)
      REQ_ON: begin
        for (int v = 0; v < VOICES; v++) begin
          if (m_phase[v] == PH_IDLE) begin
            pick = v;
            break;
          end
          if (m_age[v] < m_age[oldest]) oldest = v;
        end
        busy = (pick < 0);
        if (busy) pick = oldest;
        if (busy) n_steals++;
        m_note[pick]  = rq.note;
        m_phase[pick] = PH_ATTACK;
        m_rate[pick]  = per_tick(LEVEL_MAX - m_level[pick], m_attack);
        m_age[pick]   = m_stamp;
        m_stamp       = m_stamp + 32'd1;
        pending_reports.push_back(report(pick, 1'b1, busy, PH_ATTACK, m_level[pick], 1'b1));
      end
      REQ_OFF: begin
        for (int v = 0; v < VOICES; v++)
          if (m_note[v] == rq.note && m_phase[v] != PH_IDLE && m_phase[v] != PH_RELEASE &&
              (pick < 0 || m_age[v] < m_age[pick]))
            pick = v;
        if (pick < 0) pending_reports.push_back(report(0, 1'b0, 1'b0, PH_IDLE, 32'd0, 1'b1));
        else begin
          m_phase[pick] = PH_RELEASE;
          m_rate[pick]  = per_tick(m_level[pick], m_release);
          pending_reports.push_back(report(pick, 1'b1, 1'b0, PH_RELEASE, m_level[pick],
                                           1'b1));
        end
      end
      REQ_TICK: begin
        for (int v = 0; v < VOICES; v++) begin
          advance_voice(v);
          pending_reports.push_back(report(v, 1'b1, 1'b0, m_phase[v], m_level[v],
                                           v == VOICES - 1));
        end
      end
      default: ;  // unknown request: dropped by the block, nothing expected
    endcase
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endfunction

  // Sample both handshakes at the rising edge; predict and compare.
  always @(posedge clk) begin
    voice_report_t want;
    in_acc = rst_n && in_tvalid && in_tready;
    if (in_acc) begin
      request_t rq;
      rq.req  = in_tuser;
      rq.note = in_tdata[6:0];
      n_requests++;
      apply_request(rq);
    end
    if (rst_n && out_tvalid && out_tready) begin
      n_reports++;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item, got %h last %b", $time, out_tdata, out_tlast);
      end else begin
        want = pending_reports.pop_front();
        check_field("voice_index", 32'(want.idx), 32'(out_tdata[5:0]));
        check_field("found", 32'(want.found), 32'(out_tdata[6]));
        check_field("stolen", 32'(want.stolen), 32'(out_tdata[7]));
        check_field("phase", 32'(want.phase), 32'(out_tdata[10:8]));
        check_field("amplitude", want.amp, out_tdata[42:11]);
        check_field("last_of_run", 32'(want.last), 32'(out_tlast));
      end
    end
  end

  // Sender: advance to the next request once the current one is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_acc)) begin
      if (note_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        request_t rq;
        rq = note_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {1'b0, rq.note};
        in_tuser  <= rq.req;
      end else in_tvalid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Write one register through the configuration channel.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ATTACK:  m_attack  = val;
      CFG_DECAY:   m_decay   = val;
      CFG_SUSTAIN: m_sustain = val;
      default:     m_release = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_envelope(logic [31:0] a, logic [31:0] d, logic [31:0] s,
                              logic [31:0] r);
    write_reg(CFG_ATTACK, a);
    write_reg(CFG_DECAY, d);
    write_reg(CFG_SUSTAIN, s);
    write_reg(CFG_RELEASE, r);
  endtask

  task automatic queue_request(logic [1:0] req, logic [6:0] note);
    request_t rq;
    rq.req = req;
    rq.note = note;
    note_requests.push_back(rq);
  endtask

  // Mostly a handful of notes so note-offs find their voices.
  task automatic queue_random(int count);
    int r;
    logic [6:0] nt;
    for (int i = 0; i < count; i++) begin
      r  = $urandom_range(99);
      nt = ($urandom_range(4) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(7));
      if (r < 4)       queue_request(REQ_NONE, nt);
      else if (r < 38) queue_request(REQ_ON, nt);
      else if (r < 60) queue_request(REQ_OFF, nt);
      else             queue_request(REQ_TICK, nt);
    end
  endtask

  // Hold until every request is taken and every result has come back.
  task automatic drain();
    do @(posedge clk);
    while (note_requests.size() > 0 || in_tvalid || pending_reports.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    m_attack = RST_LENGTH; m_decay = RST_LENGTH;
    m_sustain = RST_SUSTAIN; m_release = RST_LENGTH;
    m_stamp = '0;
    for (int v = 0; v < VOICES; v++) begin
      m_note[v] = '0; m_phase[v] = PH_IDLE; m_level[v] = '0; m_rate[v] = '0; m_age[v] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset lengths: a note-on and one tick with long envelopes.
    queue_request(REQ_ON, 7'd64);
    queue_request(REQ_TICK, 7'd0);
    drain();

    // Directed: short envelope, no-match off, oldest match, stealing, dropped kind.
    set_envelope(32'd2, 32'd3, RST_SUSTAIN, 32'd2);
    queue_request(REQ_ON, 7'd0);
    queue_request(REQ_ON, 7'd127);
    queue_request(REQ_OFF, 7'd5);
    queue_request(REQ_TICK, 7'd127);
    queue_request(REQ_TICK, 7'd0);
    queue_request(REQ_OFF, 7'd127);
    queue_request(REQ_ON, 7'd0);
    queue_request(REQ_OFF, 7'd0);
    queue_request(REQ_TICK, 7'd85);
    queue_request(REQ_TICK, 7'd42);
    for (int n = 1; n <= 9; n++) queue_request(REQ_ON, 7'(n));
    queue_request(REQ_NONE, 7'd127);
    queue_request(REQ_OFF, 7'd0);
    queue_request(REQ_TICK, 7'd0);
    queue_request(REQ_TICK, 7'd0);
    queue_request(REQ_TICK, 7'd0);
    drain();

    // Fastest envelope, floor sustain, no idling.
    set_envelope(32'd1, 32'd1, 32'd0, 32'd1);
    queue_random(95);
    drain();

    // Slowest envelope, ceiling sustain, sender gaps.
    sender_idle_pct = 62;
    set_envelope(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random(95);
    drain();

    // Short random envelope, receiver stalls and one long hold-off.
    sender_idle_pct = 0;
    stall_pct = 62;
    set_envelope($urandom_range(16, 1), $urandom_range(16, 1), $urandom(),
                 $urandom_range(16, 1));
    hold_go = 1;
    queue_random(95);
    drain();

    // Both sides idle; zero lengths behave as one.
    sender_idle_pct = 30;
    stall_pct = 30;
    set_envelope(32'd0, $urandom_range(8, 1), $urandom(), 32'd0);
    queue_random(95);
    drain();

    // Mixed lengths, back to full speed.
    sender_idle_pct = 0;
    stall_pct = 0;
    set_envelope($urandom_range(40, 1), $urandom_range(40, 1), $urandom(),
                 $urandom_range(40, 1));
    queue_random(95);
    drain();

    $display("Covered %0d requests and %0d result items (%0d voice steals)",
             n_requests, n_reports, n_steals);
    $display("over six envelope settings with sender gaps and receiver stalls.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
